// ===== rtl/pod_pkg.sv =====
`timescale 1ns / 1ps
package pod_pkg;

    localparam int PITCH_W = 17;
    localparam int INDEX_W = 16;
    localparam int THR_W   = 12;

    localparam logic [THR_W-1:0]   THR_RESET = 12'd8;
    localparam logic [INDEX_W-1:0] COUNT_MAX = 16'hFFFF;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FILL,
        ST_MEDIAN,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic start;
        logic read_step;
        logic median;
        logic decide;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic judge;
        logic read_done;
        logic boundary;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/pod_ctrl.sv =====
`timescale 1ns / 1ps
module pod_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  pod_pkg::status_t status,
    output pod_pkg::cmd_t    cmd
);

    pod_pkg::state_t state_reg;
    pod_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pod_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            pod_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = pod_pkg::ST_CHECK;
                end
            end
            pod_pkg::ST_CHECK: begin
                if (status.judge) begin
                    cmd.start  = 1'b1;
                    state_next = pod_pkg::ST_FILL;
                end else begin
                    state_next = pod_pkg::ST_IDLE;
                end
            end
            pod_pkg::ST_FILL: begin
                if (status.read_done) begin
                    state_next = pod_pkg::ST_MEDIAN;
                end else begin
                    cmd.read_step = 1'b1;
                end
            end
            pod_pkg::ST_MEDIAN: begin
                cmd.median = 1'b1;
                state_next = pod_pkg::ST_DECIDE;
            end
            pod_pkg::ST_DECIDE: begin
                cmd.decide = 1'b1;
                if (status.boundary) begin
                    state_next = pod_pkg::ST_EMIT;
                end else begin
                    state_next = pod_pkg::ST_IDLE;
                end
            end
            pod_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = pod_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pod_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/pod_datapath.sv =====
`timescale 1ns / 1ps
module pod_datapath #(
    parameter int MIN_SPACE = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pod_pkg::cmd_t                 cmd,
    output pod_pkg::status_t              status,
    input  logic [pod_pkg::PITCH_W-1:0]   in_pitch,
    input  logic                          in_region_start,
    input  logic                          cfg_valid,
    input  logic [pod_pkg::THR_W-1:0]     cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pod_pkg::INDEX_W-1:0]   out_boundary_index,
    output logic [pod_pkg::PITCH_W-1:0]   out_note_value
);

    localparam int HIST_DEPTH = 1 << $clog2(MIN_SPACE + MIN_SPACE / 2 + 1);
    localparam int ADDR_W     = $clog2(HIST_DEPTH);
    localparam int CNT_W      = $clog2(MIN_SPACE + 1);
    localparam int SLOT_W     = (MIN_SPACE > 1) ? $clog2(MIN_SPACE) : 1;
    localparam int PW         = pod_pkg::PITCH_W;
    localparam int IW         = pod_pkg::INDEX_W;

    logic [PW-1:0] hist_mem [HIST_DEPTH];

    logic [IW-1:0]          frame_count_reg;
    logic [PW-1:0]          last_note_reg;
    logic [IW-1:0]          last_boundary_reg;
    logic [pod_pkg::THR_W-1:0] thr_reg;
    logic                   judge_reg;
    logic [IW-1:0]          judge_idx_reg;
    logic [ADDR_W-1:0]      rd_ptr_reg;
    logic [CNT_W-1:0]       rd_cnt_reg;
    logic                   rd_valid_reg;
    logic [PW-1:0]          rd_data_reg;
    logic [PW-1:0]          sorted_reg [MIN_SPACE];
    logic [PW-1:0]          sorted_next [MIN_SPACE];
    logic [CNT_W-1:0]       sort_cnt_reg;
    logic [PW-1:0]          med_reg;
    logic                   out_valid_reg;
    logic [IW-1:0]          out_index_reg;
    logic [PW-1:0]          out_note_reg;

    logic [IW-1:0]          base_count;
    logic                   store;
    logic [MIN_SPACE-1:0]   gt;
    logic [CNT_W-1:0]       half_cnt;
    logic [PW-1:0]          diff;
    logic                   note_change;
    logic [IW:0]            boundary_limit;

    assign base_count = in_region_start ? '0 : frame_count_reg;
    assign store      = (base_count != pod_pkg::COUNT_MAX);

    always_ff @(posedge aclk) begin
        if (cmd.accept && store) begin
            hist_mem[base_count[ADDR_W-1:0]] <= in_pitch;
        end
        if (cmd.read_step) begin
            rd_data_reg <= hist_mem[rd_ptr_reg];
        end
    end

    always_comb begin
        for (int p = 0; p < MIN_SPACE; p++) begin
            gt[p] = (CNT_W'(p) < sort_cnt_reg) && (sorted_reg[p] > rd_data_reg);
        end
        for (int p = 0; p < MIN_SPACE; p++) begin
            if (p > 0 && gt[(p > 0) ? p - 1 : 0]) begin
                sorted_next[p] = sorted_reg[(p > 0) ? p - 1 : 0];
            end else if (gt[p] || (CNT_W'(p) == sort_cnt_reg)) begin
                sorted_next[p] = rd_data_reg;
            end else begin
                sorted_next[p] = sorted_reg[p];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_valid_reg && (rd_data_reg != '0)) begin
            for (int p = 0; p < MIN_SPACE; p++) begin
                sorted_reg[p] <= sorted_next[p];
            end
        end
    end

    assign half_cnt       = sort_cnt_reg >> 1;
    assign diff           = (med_reg > last_note_reg) ? (med_reg - last_note_reg)
                                                      : (last_note_reg - med_reg);
    assign note_change    = diff > PW'(thr_reg);
    assign boundary_limit = {1'b0, last_boundary_reg} + (IW + 1)'(MIN_SPACE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg   <= '0;
            last_note_reg     <= '0;
            last_boundary_reg <= '0;
            thr_reg           <= pod_pkg::THR_RESET;
            judge_reg         <= 1'b0;
            rd_cnt_reg        <= '0;
            rd_valid_reg      <= 1'b0;
            sort_cnt_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.read_step;
            if (cfg_valid) begin
                thr_reg <= cfg_data;
            end
            if (cmd.accept) begin
                if (in_region_start) begin
                    last_note_reg     <= '0;
                    last_boundary_reg <= '0;
                end
                frame_count_reg <= store ? base_count + 1'b1 : base_count;
                judge_reg       <= store &&
                                   ((IW + 1)'(base_count) >= (IW + 1)'(2 * MIN_SPACE));
                judge_idx_reg   <= base_count - IW'(MIN_SPACE);
            end
            if (cmd.start) begin
                rd_ptr_reg   <= judge_idx_reg[ADDR_W-1:0] - ADDR_W'(MIN_SPACE / 2);
                rd_cnt_reg   <= '0;
                sort_cnt_reg <= '0;
            end
            if (cmd.read_step) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
            if (rd_valid_reg && (rd_data_reg != '0)) begin
                sort_cnt_reg <= sort_cnt_reg + 1'b1;
            end
            if (cmd.median) begin
                med_reg <= (sort_cnt_reg == '0) ? '0 : sorted_reg[half_cnt[SLOT_W-1:0]];
            end
            if (cmd.decide && note_change) begin
                last_note_reg <= med_reg;
                if (status.boundary) begin
                    last_boundary_reg <= judge_idx_reg;
                end
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
                out_index_reg <= judge_idx_reg;
                out_note_reg  <= med_reg;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.judge     = judge_reg;
    assign status.read_done = (rd_cnt_reg == CNT_W'(MIN_SPACE));
    assign status.boundary  = note_change && ((IW + 1)'(judge_idx_reg) > boundary_limit);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid          = out_valid_reg;
    assign out_boundary_index = out_index_reg;
    assign out_note_value     = out_note_reg;

endmodule

// ===== rtl/pitch_onset_detector_top.sv =====
`timescale 1ns / 1ps
// Detects note boundaries in a stream of pitch frames (unsigned Q13.4, zero for unvoiced);
// s_tuser marks the first frame of a region and clears the history. Frame i is judged when
// frame i + MIN_SPACE arrives: the upper median of the nonzero pitches around it is compared
// against the last note, and a request carrying (index, median) is sent when the change
// exceeds the threshold and i lies more than MIN_SPACE frames past the last boundary. A new
// frame is taken only when idle, after the judgement and any request of the last one; the
// history memory gives one window value per cycle to the insertion sorter. The threshold is to
// be written through the cfg port only while the block is idle; the block does not enforce it.
module pitch_onset_detector_top #(
    parameter int MIN_SPACE = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [16:0] pitch
    input  logic [pod_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] region_start
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] boundary_index, [32:16] note_value
    output logic [pod_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pod_pkg::THR_W-1:0]         cfg_data
);

    pod_pkg::cmd_t    cmd;
    pod_pkg::status_t status;

    logic [pod_pkg::INDEX_W-1:0] boundary_index;
    logic [pod_pkg::PITCH_W-1:0] note_value;

    assign cfg_ready = 1'b1;

    pod_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pod_datapath #(
        .MIN_SPACE (MIN_SPACE)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .in_pitch           (s_tdata[pod_pkg::PITCH_W-1:0]),
        .in_region_start    (s_tuser),
        .cfg_valid          (cfg_valid),
        .cfg_data           (cfg_data),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .out_boundary_index (boundary_index),
        .out_note_value     (note_value)
    );

    assign m_tdata = {7'd0, note_value, boundary_index};

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("Request accepted while the previous one is still in work.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("Result loaded over a request that was not taken.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.read_step |-> !status.read_done)
        else $error("History read beyond the median window.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> $past(cmd.decide) || $past(cmd.emit == 1'b0 && !s_tready))
        else $error("Result emitted without a decision.");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;

    localparam int MIN_SPACE = 8;
    localparam int RING_DEPTH = 16;
    localparam int SETTLE_CYCLES = 3 * (MIN_SPACE + 6);
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PITCH_TOP = (1 << pod_pkg::PITCH_W) - 1;

    typedef struct {
        logic [pod_pkg::INDEX_W-1:0] index;
        logic [pod_pkg::PITCH_W-1:0] note;
    } boundary_t;

    class onset_scoreboard;
        logic [pod_pkg::PITCH_W-1:0] pitch_ring [RING_DEPTH];
        int frames_in_region;
        int last_note;
        int last_boundary;
        int note_threshold;
        boundary_t expected_boundaries [$];
        int errors;

        function new();
            note_threshold = int'(pod_pkg::THR_RESET);
            errors = 0;
            clear_region();
        endfunction

        function void clear_region();
            foreach (pitch_ring[k]) pitch_ring[k] = '0;
            frames_in_region = 0;
            last_note = 0;
            last_boundary = 0;
        endfunction

        function void set_threshold(logic [pod_pkg::THR_W-1:0] value);
            note_threshold = int'(value);
        endfunction

        function int window_median(int first);
            int vals [MIN_SPACE];
            int cnt;
            int v;
            int p;
            cnt = 0;
            for (int k = 0; k < MIN_SPACE; k++) begin
                v = int'(pitch_ring[(first + k) % RING_DEPTH]);
                if (v != 0) begin
                    p = cnt;
                    while (p > 0 && vals[p-1] > v) begin
                        vals[p] = vals[p-1];
                        p--;
                    end
                    vals[p] = v;
                    cnt++;
                end
            end
            return (cnt == 0) ? 0 : vals[cnt / 2];
        endfunction

        function void note_frame(logic [pod_pkg::PITCH_W-1:0] pitch, logic region_start);
            int n;
            int i;
            int med;
            int diff;
            boundary_t b;
            if (region_start) clear_region();
            if (frames_in_region >= int'(pod_pkg::COUNT_MAX)) return;
            n = frames_in_region;
            pitch_ring[n % RING_DEPTH] = pitch;
            frames_in_region = n + 1;
            if (n < 2 * MIN_SPACE) return;
            i = n - MIN_SPACE;
            med = window_median(i - MIN_SPACE / 2);
            diff = (med > last_note) ? med - last_note : last_note - med;
            if (diff <= note_threshold) return;
            last_note = med;
            if (i > last_boundary + MIN_SPACE) begin
                last_boundary = i;
                b.index = i[pod_pkg::INDEX_W-1:0];
                b.note = med[pod_pkg::PITCH_W-1:0];
                expected_boundaries.push_back(b);
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100) $display("tb: mismatch: %s", msg);
        endtask

        task check_boundary(logic [pod_pkg::INDEX_W-1:0] index,
                            logic [pod_pkg::PITCH_W-1:0] note);
            boundary_t b;
            if (expected_boundaries.size() == 0) begin
                report($sformatf("unexpected boundary index %0d note %0d", index, note));
                return;
            end
            b = expected_boundaries.pop_front();
            if (index !== b.index)
                report($sformatf("boundary index %0d, expected %0d", index, b.index));
            if (note !== b.note)
                report($sformatf("note value %0d at index %0d, expected %0d",
                                 note, b.index, b.note));
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [pod_pkg::S_TDATA_W-1:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [pod_pkg::M_TDATA_W-1:0] m_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [pod_pkg::THR_W-1:0] cfg_data;

    onset_scoreboard sb = new();
    int src_idle = 0;
    int snk_idle = 0;
    int frames_sent = 0;
    int quiet_cycles = 0;

    pitch_onset_detector_top #(
        .MIN_SPACE(MIN_SPACE)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_idle);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_frame(s_tdata[pod_pkg::PITCH_W-1:0], s_tuser);
            if (m_tvalid && m_tready)
                sb.check_boundary(m_tdata[pod_pkg::INDEX_W-1:0],
                    m_tdata[pod_pkg::INDEX_W+pod_pkg::PITCH_W-1:pod_pkg::INDEX_W]);
            if (cfg_valid && cfg_ready) sb.set_threshold(cfg_data);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [pod_pkg::PITCH_W-1:0] clamp_pitch(int value);
        if (value < 0) return '0;
        if (value > PITCH_TOP) return PITCH_TOP[pod_pkg::PITCH_W-1:0];
        return value[pod_pkg::PITCH_W-1:0];
    endfunction

    task automatic send_frame(input logic [pod_pkg::PITCH_W-1:0] pitch,
                              input logic region_start);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(pod_pkg::S_TDATA_W-pod_pkg::PITCH_W){1'b0}}, pitch};
        s_tuser <= region_start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        frames_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_boundaries.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [pod_pkg::THR_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Notes held for a few frames, with unvoiced gaps and small jitter.
    task automatic send_region(input bit with_start);
        int len;
        int hold;
        int note;
        int r;
        logic [pod_pkg::PITCH_W-1:0] p;
        len = $urandom_range(17, 60);
        hold = 0;
        note = 0;
        for (int k = 0; k < len; k++) begin
            if (hold == 0) begin
                hold = $urandom_range(3, 14);
                case ($urandom_range(5))
                    0: note = 0;
                    1, 2: note = $urandom_range(1, PITCH_TOP);
                    default: note = int'(clamp_pitch(note + int'($urandom_range(8192)) - 4096));
                endcase
            end
            hold--;
            r = $urandom_range(99);
            if (r < 12) p = '0;
            else if (r < 27) p = clamp_pitch(note + int'($urandom_range(30)) - 15);
            else p = note[pod_pkg::PITCH_W-1:0];
            send_frame(p, with_start && k == 0);
        end
    endtask

    task automatic run_random(input int items);
        int stop;
        stop = frames_sent + items;
        while (frames_sent < stop) begin
            case ($urandom_range(9))
                7: begin
                    repeat ($urandom_range(1, 20))
                        send_frame(pod_pkg::PITCH_W'($urandom), $urandom_range(7) == 0);
                end
                8: begin
                    send_frame(pod_pkg::PITCH_W'($urandom), 1'b1);
                    repeat ($urandom_range(0, 14))
                        send_frame(pod_pkg::PITCH_W'($urandom), 1'b0);
                end
                9: send_region(1'b0);
                default: send_region(1'b1);
            endcase
        end
    endtask

    task automatic run_directed();
        logic [pod_pkg::PITCH_W-1:0] pitches [24];
        logic starts [24];
        pitches = '{17'd0, 17'h1FFFF, 17'd1, 17'd16, 17'd16, 17'd16, 17'd0, 17'd16,
                    17'd16, 17'd16, 17'd16, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF,
                    17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h10000, 17'd5,
                    17'h15555, 17'h0AAAA, 17'd0};
        foreach (starts[k]) starts[k] = (k == 20 || k == 23);
        foreach (pitches[k]) send_frame(pitches[k], starts[k]);
    endtask

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle = 28;
        snk_idle = 79;
        run_directed();
        write_threshold('0);
        run_random(270);

        src_idle = 79;
        snk_idle = 28;
        write_threshold({pod_pkg::THR_W{1'b1}});
        run_random(270);

        src_idle = 0;
        snk_idle = 0;
        write_threshold(pod_pkg::THR_W'($urandom_range(1, 4094)));
        run_random(260);

        wait_idle();
        if (sb.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
